[rtl/core/stopwatch_seven_segment_scan_macros.svh]
// assertion macros shared by the stopwatch checker
`ifndef STOPWATCH_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define STOPWATCH_SEVEN_SEGMENT_SCAN_MACROS_SVH

// same-cycle implication, disabled during reset
`define SWSS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stopwatch check failed");

// next-cycle implication, disabled during reset
`define SWSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stopwatch check failed");

`endif

[rtl/core/swss_pkg.sv]
// shared constants, types and segment decode for the stopwatch display
`default_nettype none

package swss_pkg;

    localparam int NUM_DIGITS    = 4;
    localparam int POS_W         = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int SECONDS_DIGIT = 2;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int TICK_W        = 10;
    localparam int PRESS_W       = 16;
    localparam int DIGIT_W       = 4;
    localparam int SEG_W         = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL     = 2'd3;

    localparam logic [TICK_W-1:0]  DEBOUNCE_RST = 10'd10;
    localparam logic [PRESS_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [TICK_W-1:0]  PRESCALE_RST = 10'd10;
    localparam logic [TICK_W-1:0]  DWELL_RST    = 10'd5;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [SEG_W-1:0]   DP_MASK   = 8'h80;

    // button outcome handed from the press timer to the counter
    typedef struct packed {
        logic clear_count;
        logic running;
        logic running_next;
    } swss_press_t;

    // seven-segment decode, codes above nine are dark
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h67;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/core/swss_digit_cell.sv]
// one bcd digit of the count chain, carry passes to the next digit
`default_nettype none

module swss_digit_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          inc_in,
    input  wire logic                          clear,
    output logic                               carry_out,
    output logic [swss_pkg::DIGIT_W-1:0]       digit_next
);
    import swss_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;

    // increment with wrap past nine, clear wins
    always_comb begin
        carry_out  = inc_in && (digit_reg >= DIGIT_MAX);
        digit_next = digit_reg;
        if (clear) begin
            digit_next = '0;
        end else if (inc_in) begin
            digit_next = (digit_reg >= DIGIT_MAX) ? '0 : digit_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/swss_press.sv]
// press timer and run/stop toggle, acts on the release beat
`default_nettype none

module swss_press (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic                          pressed,
    input  wire logic [swss_pkg::TICK_W-1:0]   debounce_ticks,
    input  wire logic [swss_pkg::PRESS_W-1:0]  long_press_ticks,
    output swss_pkg::swss_press_t              press
);
    import swss_pkg::*;

    logic [PRESS_W-1:0] press_len_reg, press_len_next;
    logic               button_last_reg, button_last_next;
    logic               running_reg, running_next;
    logic               clear_now;

    // press length, release decision
    always_comb begin
        press_len_next   = press_len_reg;
        button_last_next = button_last_reg;
        running_next     = running_reg;
        clear_now        = 1'b0;
        if (accept) begin
            button_last_next = pressed;
            if (pressed) begin
                if (press_len_reg != {PRESS_W{1'b1}}) begin
                    press_len_next = press_len_reg + 1'b1;
                end
            end else if (button_last_reg) begin
                if (press_len_reg > long_press_ticks) begin
                    clear_now = 1'b1;
                end else if (press_len_reg > {{(PRESS_W-TICK_W){1'b0}}, debounce_ticks}) begin
                    running_next = !running_reg;
                end
                press_len_next = '0;
            end
        end
    end

    assign press.clear_count  = clear_now;
    assign press.running      = running_reg;
    assign press.running_next = running_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_len_reg   <= '0;
            button_last_reg <= 1'b0;
            running_reg     <= 1'b0;
        end else begin
            press_len_reg   <= press_len_next;
            button_last_reg <= button_last_next;
            running_reg     <= running_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/stopwatch_seven_segment_scan.sv]
// stopwatch top: one tick beat in, one display beat out, registered in the output register
// throughput one beat per cycle while m_ready does not stall the output; the output register frees as its beat is taken
// the bcd chain ripples its carry combinationally through all digit cells
// reset (synchronous, active low) stops the watch, zeroes count, scan and timers
// and loads the register defaults: debounce 10, long press 1000, prescale 10, dwell 5
`default_nettype none

module stopwatch_seven_segment_scan (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_button_pressed,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [swss_pkg::NUM_DIGITS-1:0]        m_digit_enable,
    output logic [swss_pkg::SEG_W-1:0]             m_segments,
    output logic                                   m_is_running,
    input  wire logic                              cfg_we,
    input  wire logic [swss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [swss_pkg::CFG_W-1:0]        cfg_wdata
);
    import swss_pkg::*;

    logic [TICK_W-1:0]  debounce_reg, prescale_lim_reg, dwell_lim_reg;
    logic [PRESS_W-1:0] long_reg;

    logic               accept;
    swss_press_t        press;

    logic [TICK_W-1:0]  prescale_reg, prescale_next, prescale_inc, prescale_lim;
    logic               step;
    logic [NUM_DIGITS:0]              carry;
    logic [DIGIT_W-1:0]               digit_next [NUM_DIGITS];

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TICK_W-1:0]  dwell_reg, dwell_next, dwell_inc, dwell_lim;

    logic [DIGIT_W-1:0]    shown_digit;
    logic [SEG_W-1:0]      seg_val;
    logic [NUM_DIGITS-1:0] enable_val;

    logic                  m_valid_reg;
    logic [NUM_DIGITS-1:0] enable_reg;
    logic [SEG_W-1:0]      seg_reg;
    logic                  running_out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= DEBOUNCE_RST;
            long_reg         <= LONG_RST;
            prescale_lim_reg <= PRESCALE_RST;
            dwell_lim_reg    <= DWELL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg     <= cfg_wdata[TICK_W-1:0];
                REG_LONG:     long_reg         <= cfg_wdata[PRESS_W-1:0];
                REG_PRESCALE: prescale_lim_reg <= cfg_wdata[TICK_W-1:0];
                REG_DWELL:    dwell_lim_reg    <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    swss_press u_press (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .pressed          (s_button_pressed),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_reg),
        .press            (press)
    );

    // hundredths prescaler, zero limit acts as one
    always_comb begin
        prescale_lim  = (prescale_lim_reg == '0) ? TICK_W'(1) : prescale_lim_reg;
        prescale_inc  = prescale_reg + 1'b1;
        prescale_next = prescale_reg;
        step          = 1'b0;
        if (accept && press.running) begin
            if (prescale_inc >= prescale_lim) begin
                prescale_next = '0;
                step          = 1'b1;
            end else begin
                prescale_next = prescale_inc;
            end
        end
        if (press.clear_count) begin
            prescale_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
        end else begin
            prescale_reg <= prescale_next;
        end
    end

    // chain of digit cells, hundredths first
    assign carry[0] = step;

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
        swss_digit_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .inc_in     (carry[i]),
            .clear      (press.clear_count),
            .carry_out  (carry[i+1]),
            .digit_next (digit_next[i])
        );
    end

    // display of the digit under scan, using the updated count
    always_comb begin
        shown_digit = digit_next[pos_reg];
        seg_val     = seg_decode(shown_digit);
        if ((pos_reg == POS_W'(NUM_DIGITS - 1)) && (shown_digit == '0)) begin
            seg_val = '0;
        end
        if ((NUM_DIGITS > SECONDS_DIGIT) && (pos_reg == POS_W'(SECONDS_DIGIT))) begin
            seg_val = seg_val | DP_MASK;
        end
        enable_val = ~(NUM_DIGITS'(1) << pos_reg);
    end

    // scan advance, zero dwell acts as one
    always_comb begin
        dwell_lim  = (dwell_lim_reg == '0) ? TICK_W'(1) : dwell_lim_reg;
        dwell_inc  = dwell_reg + 1'b1;
        dwell_next = dwell_reg;
        pos_next   = pos_reg;
        if (accept) begin
            if (dwell_inc >= dwell_lim) begin
                dwell_next = '0;
                pos_next   = (pos_reg == POS_W'(NUM_DIGITS - 1)) ? '0 : pos_reg + 1'b1;
            end else begin
                dwell_next = dwell_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_reg <= '0;
            pos_reg   <= '0;
        end else begin
            dwell_reg <= dwell_next;
            pos_reg   <= pos_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            enable_reg      <= enable_val;
            seg_reg         <= seg_val;
            running_out_reg <= press.running_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_digit_enable = enable_reg;
    assign m_segments     = seg_reg;
    assign m_is_running   = running_out_reg;

endmodule

`default_nettype wire

[rtl/core/swss_checker.sv]
// port-level checks for the stopwatch display, bound to the top level
`default_nettype none
`include "stopwatch_seven_segment_scan_macros.svh"

module swss_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [swss_pkg::NUM_DIGITS-1:0]   m_digit_enable,
    input wire logic [swss_pkg::SEG_W-1:0]        m_segments,
    input wire logic                              m_is_running
);
    import swss_pkg::*;

    // exactly one digit line driven low
    `SWSS_ASSERT_NOW(a_one_digit, aclk, aresetn, m_valid, $onehot(~m_digit_enable))

    // decimal point only on the seconds digit
    `SWSS_ASSERT_NOW(a_dp_seconds, aclk, aresetn, m_valid, m_segments[SEG_W-1] == !m_digit_enable[SECONDS_DIGIT])

    // a zero in the top digit is blanked, never drawn
    `SWSS_ASSERT_NOW(a_lead_blank, aclk, aresetn, m_valid && !m_digit_enable[NUM_DIGITS-1], m_segments != 8'h3F)

    // a stalled result beat holds
    `SWSS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_segments) && $stable(m_digit_enable) && $stable(m_is_running))

endmodule

bind stopwatch_seven_segment_scan swss_checker u_swss_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_digit_enable (m_digit_enable),
    .m_segments     (m_segments),
    .m_is_running   (m_is_running)
);

`default_nettype wire
